/* src/pca_pkg.sv */
package pca_pkg;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int OFS_W   = 9;
    localparam int LVL_W   = 10;
    localparam int GAIN_W  = 25;
    localparam int IDX_W   = 2;
    localparam int PROD_W  = GAIN_W + 1 + OFS_W;
    localparam int FRAC_W  = 16;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(1) << (GAIN_W - 1);
    localparam logic [4:0]        DIV_TOP  = 5'(GAIN_W - 1);

    localparam logic [CH_W-1:0]   CENTER   = 8'd127;
    localparam logic [CH_W-1:0]   CH_MAX   = 8'd255;

    // floor(s/3) == (s*683) >> 11 for every s below 2048
    localparam logic [9:0]        AVG_RECIP = 10'd683;
    localparam int                AVG_SHIFT = 11;

    localparam logic [IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET   = 2'd1;
    localparam logic [IDX_W-1:0] REG_CONTRAST = 2'd2;

    localparam logic [1:0] MODE_GRAY     = 2'd0;
    localparam logic [1:0] MODE_BRIGHT   = 2'd1;
    localparam logic [1:0] MODE_CONTRAST = 2'd2;

    typedef struct packed {
        logic adv1;
        logic adv2;
    } t_pipe_en;

    typedef struct packed {
        logic [CH_W-1:0] contrast;
        logic [CH_W-1:0] bright;
        logic [CH_W-1:0] raw;
    } t_lane_res;

endpackage

/* src/pca_gain_div.sv */
module pca_gain_div import pca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [LVL_W-1:0]  i_level,
    output logic [GAIN_W-1:0] o_gain,
    output logic              o_busy
);

    logic [GAIN_W-1:0] r_gain, n_gain;
    logic              r_busy, n_busy;
    logic [4:0]        r_cnt, n_cnt;
    logic [7:0]        r_rem, n_rem;
    logic [8:0]        r_div, n_div;

    logic signed [LVL_W-1:0] level;
    logic [LVL_W-1:0]        lvl_sum;
    logic signed [10:0]      div_diff;
    logic [8:0]              shifted;
    logic                    ge;
    logic [8:0]              rem_next;

    assign level    = $signed(i_level);
    assign lvl_sum  = 10'(level + 10'sd256);
    assign div_diff = 11'sd257 - 11'(level);

    // restoring division of 2^24: the only dividend bit set is the top one
    assign shifted  = {r_rem, (r_cnt == DIV_TOP)};
    assign ge       = (shifted >= r_div);
    assign rem_next = ge ? (shifted - r_div) : shifted;

    always_comb begin
        n_gain = r_gain;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_load) begin
            n_busy = 1'b0;
            if (level < -10'sd256) begin
                n_gain = '0;
            end else if (level <= 10'sd0) begin
                n_gain = GAIN_W'({lvl_sum[8:0], 8'd0});
            end else if (level >= 10'sd256) begin
                n_gain = GAIN_MAX;
            end else begin
                n_busy = 1'b1;
                n_cnt  = DIV_TOP;
                n_rem  = '0;
                n_gain = '0;
                n_div  = div_diff[8:0];
            end
        end else if (r_busy) begin
            n_rem  = rem_next[7:0];
            n_gain = {r_gain[GAIN_W-2:0], ge};
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
            r_busy <= 1'b0;
        end else begin
            r_gain <= n_gain;
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_gain = r_gain;
    assign o_busy = r_busy;

endmodule

/* src/pca_lane.sv */
module pca_lane import pca_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  logic [CH_W-1:0]   i_chan,
    input  logic [OFS_W-1:0]  i_offset,
    input  logic [GAIN_W-1:0] i_gain,
    output t_lane_res         o_res
);

    logic signed [PROD_W-1:0] r_prod;
    logic [CH_W-1:0]          r_bright;
    logic [CH_W-1:0]          r_raw;

    logic signed [OFS_W-1:0]  delta;
    logic signed [PROD_W-1:0] prod;
    logic signed [LVL_W-1:0]  bsum;
    logic [CH_W-1:0]          bright;
    logic signed [18:0]       quot;
    logic signed [19:0]       csum;
    logic [CH_W-1:0]          contrast;

    assign delta = $signed({1'b0, i_chan}) - $signed({1'b0, CENTER});
    assign bsum  = $signed({2'b00, i_chan}) + LVL_W'($signed(i_offset));
    assign prod  = $signed({1'b0, i_gain}) * delta;

    always_comb begin
        if (bsum < 10'sd0) begin
            bright = '0;
        end else if (bsum > 10'sd255) begin
            bright = CH_MAX;
        end else begin
            bright = bsum[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.adv1) begin
            r_prod   <= prod;
            r_bright <= bright;
            r_raw    <= i_chan;
        end
    end

    // arithmetic shift gives the floor for negative products as well
    assign quot = r_prod[PROD_W-1:FRAC_W];
    assign csum = 20'(quot) + $signed({12'd0, CENTER});

    always_comb begin
        if (csum < 20'sd0) begin
            contrast = '0;
        end else if (csum > 20'sd255) begin
            contrast = CH_MAX;
        end else begin
            contrast = csum[CH_W-1:0];
        end
    end

    assign o_res.contrast = contrast;
    assign o_res.bright   = r_bright;
    assign o_res.raw      = r_raw;

endmodule

/* src/pca_merge.sv */
module pca_merge import pca_pkg::*; (
    input  logic             i_clk,
    input  t_pipe_en         i_en,
    input  logic [PIX_W-1:0] i_pix,
    input  logic [1:0]       i_mode,
    input  t_lane_res        i_res [3],
    output logic [PIX_W-1:0] o_pix
);

    logic [CH_W-1:0]  r_avg;
    logic [PIX_W-1:0] r_pix, n_pix;

    logic [9:0]  sum;
    logic [19:0] avg_prod;

    assign sum = 10'(i_pix[7:0]) + 10'(i_pix[15:8]) + 10'(i_pix[23:16]);
    assign avg_prod = sum * AVG_RECIP;

    always_comb begin
        case (i_mode)
            MODE_GRAY:     n_pix = {r_avg, r_avg, r_avg};
            MODE_BRIGHT:   n_pix = {i_res[2].bright, i_res[1].bright, i_res[0].bright};
            MODE_CONTRAST: n_pix = {i_res[2].contrast, i_res[1].contrast,
                                    i_res[0].contrast};
            default:       n_pix = {i_res[2].raw, i_res[1].raw, i_res[0].raw};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.adv1) begin
            r_avg <= avg_prod[AVG_SHIFT +: CH_W];
        end
        if (i_en.adv2) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

/* src/pixel_color_adjust.sv */
// Per-pixel colour adjustment on a BGR stream. Mode 0 writes the channel
// average to all three channels, mode 1 adds the signed brightness offset,
// mode 2 scales each channel about level 127 by the contrast gain, mode 3
// passes the pixel through; every result saturates to 0..255. The block
// takes one pixel per clock unless the output stalls or a gain division
// runs; it keeps accepting while a result waits at the output as long as
// its first stage is free. Writing a contrast level between 1 and 255 starts
// a one-bit-a-clock gain division that holds tready low; other writes take
// effect at once. Write configuration only while no pixel is in flight.
module pixel_color_adjust import pca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [LVL_W-1:0]  i_cfg_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [PIX_W-1:0]  i_s_tdata,   // blue_in, green_in, red_in
    input  logic              i_s_tlast,   // frame_end_in
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [PIX_W-1:0]  o_m_tdata,   // blue_out, green_out, red_out
    output logic              o_m_tlast    // frame_end_out
);

    logic [1:0]       r_mode;
    logic [OFS_W-1:0] r_offset;
    logic             r_v1, r_v2;
    logic             r_last1, r_last2;

    logic [GAIN_W-1:0] gain;
    logic              busy;
    logic              accept;
    t_pipe_en          en;
    t_lane_res         res [3];

    assign en.adv2   = !r_v2 || i_m_tready;
    assign en.adv1   = accept || (r_v1 && en.adv2) || !r_v1;
    assign o_s_tready = (!r_v1 || en.adv2) && !busy;
    assign accept    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_GRAY;
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[1:0];
                REG_OFFSET: r_offset <= i_cfg_data[OFS_W-1:0];
                default:    ;
            endcase
        end
    end

    // stage 1 takes a bubble when nothing is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (!r_v1 || en.adv2) begin
                r_v1 <= accept;
            end
            if (en.adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_v1 || en.adv2) begin
            r_last1 <= i_s_tlast;
        end
        if (en.adv2) begin
            r_last2 <= r_last1;
        end
    end

    pca_gain_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cfg_wr_en && (i_cfg_index == REG_CONTRAST)),
        .i_level (i_cfg_data),
        .o_gain  (gain),
        .o_busy  (busy)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        pca_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_chan   (i_s_tdata[k*CH_W +: CH_W]),
            .i_offset (r_offset),
            .i_gain   (gain),
            .o_res    (res[k])
        );
    end

    pca_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_pix  (i_s_tdata),
        .i_mode (r_mode),
        .i_res  (res),
        .o_pix  (o_m_tdata)
    );

    assign o_m_tvalid = r_v2;
    assign o_m_tlast  = r_last2;

endmodule
